// ----- src/first_free_brick_allocator_unit_assert.svh -----
// Assertion macros for the first-free brick allocator.
// Included by ffba_datapath, the RTL file that carries concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef FIRST_FREE_BRICK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FREE_BRICK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FFBA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FFBA_ASSERT(label, prop, msg)
`define FFBA_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- src/ffba_pkg.sv -----
// Shared types and constants of the first-free brick allocator.
// No dependencies; imported by ffba_ctrl, ffba_datapath and first_free_brick_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned REG_IDX_W  = 2;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned BRICK_ID_W = 12;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned WORD_MAX   = 64;

  localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } ffba_cmd_e;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FULL  = 2'd1,
    ST_FREED = 2'd2,
    ST_RANGE = 2'd3
  } ffba_status_e;

  typedef struct packed {
    logic            cmd;
    logic [ID_W-1:0] free_id;
  } ffba_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [BRICK_ID_W-1:0] brick_id;
    logic [COORD_W-1:0]    coord_x;
    logic [COORD_W-1:0]    coord_y;
    logic [COORD_W-1:0]    coord_z;
  } ffba_out_t;

  typedef struct packed {
    logic         clr_wr;
    logic         take;
    logic         mul_plane;
    logic         mul_count;
    logic         scan_init;
    logic         rd;
    logic         next_row;
    logic         wr_alloc;
    logic         wr_free;
    logic         div_ld_x;
    logic         div_ld_y;
    logic         div_step;
    logic         ld_out;
    ffba_status_e status;
  } ffba_ctl_t;

  typedef struct packed {
    logic clr_last;
    logic req_free;
    logic free_ok;
    logic alloc_none;
    logic found;
    logic more_rows;
    logic div_last;
    logic out_free;
  } ffba_sts_t;

endpackage

`default_nettype wire

// ----- src/ffba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/ffba_ctrl.sv -----
// Sequencing state machine of the brick allocator.
// Depends on ffba_pkg; drives ffba_datapath through ffba_ctl_t and reads ffba_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl import ffba_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ffba_sts_t sts_i,
  output ffba_ctl_t      ctl_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PLANE,
    S_COUNT,
    S_START,
    S_READ,
    S_CHECK,
    S_DIVX,
    S_LDY,
    S_DIVY,
    S_DONE
  } state_e;

  state_e       state_q, state_d;
  ffba_status_e stat_q, stat_d;

  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    ctl_o   = '0;
    ctl_o.status = stat_q;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.take = 1'b1;
          state_d    = S_PLANE;
        end
      end
      S_PLANE: begin
        ctl_o.mul_plane = 1'b1;
        state_d         = S_COUNT;
      end
      S_COUNT: begin
        ctl_o.mul_count = 1'b1;
        state_d         = S_START;
      end
      S_START: begin
        ctl_o.scan_init = 1'b1;
        if (sts_i.req_free) begin
          if (sts_i.free_ok) begin
            state_d = S_READ;
          end else begin
            stat_d  = ST_RANGE;
            state_d = S_DONE;
          end
        end else if (sts_i.alloc_none) begin
          stat_d  = ST_FULL;
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        ctl_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.req_free) begin
          ctl_o.wr_free = 1'b1;
          stat_d        = ST_FREED;
          state_d       = S_DONE;
        end else if (sts_i.found) begin
          ctl_o.wr_alloc = 1'b1;
          ctl_o.div_ld_x = 1'b1;
          stat_d         = ST_ALLOC;
          state_d        = S_DIVX;
        end else if (sts_i.more_rows) begin
          ctl_o.next_row = 1'b1;
          state_d        = S_READ;
        end else begin
          stat_d  = ST_FULL;
          state_d = S_DONE;
        end
      end
      S_DIVX: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_LDY;
        end
      end
      S_LDY: begin
        ctl_o.div_ld_y = 1'b1;
        state_d        = S_DIVY;
      end
      S_DIVY: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      stat_q  <= ST_ALLOC;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- src/ffba_datapath.sv -----
// Datapath of the brick allocator: size registers, slot count, bitmap RAM,
// first-free search, shared restoring divider and result register.
// Depends on ffba_pkg, ffba_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "first_free_brick_allocator_unit_assert.svh"

module ffba_datapath import ffba_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i,
  input  wire ffba_in_t             in_data_i,
  input  wire ffba_ctl_t            ctl_i,
  output ffba_sts_t                 sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ffba_out_t                 out_data_o
);

  localparam int unsigned WORD_BITS = (MAX_SLOTS < WORD_MAX) ? (1 << $clog2(MAX_SLOTS)) : WORD_MAX;
  localparam int unsigned ROWS      = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int unsigned NB_W      = CNT_W + 1;
  localparam int unsigned CMP_W     = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam int unsigned PLANE_W   = 2 * SIZE_W;
  localparam int unsigned PROD_W    = 3 * SIZE_W;
  localparam int unsigned DCNT_W    = $clog2(CNT_W + 1);
  localparam int unsigned SH_W      = SIZE_W + 1;

  logic [SIZE_W-1:0]    size_x_q, size_y_q, size_z_q;
  ffba_in_t             req_q;
  logic [PLANE_W-1:0]   plane_q;
  logic [CNT_W-1:0]     count_q;
  logic [ROW_W-1:0]     row_q, hint_q, clr_row_q;
  logic [CNT_W-1:0]     base_q, idx_q;
  logic [CNT_W-1:0]     quo_q;
  logic [SIZE_W-1:0]    rem_q, dvs_q, x_q;
  logic [DCNT_W-1:0]    dcnt_q;
  ffba_out_t            out_q;
  logic                 out_valid_q;

  logic [PROD_W-1:0]    prod;
  logic [CNT_W-1:0]     count_sat;
  logic [CNT_W-1:0]     free_idx;
  logic [ROW_W-1:0]     free_row;
  logic [BIT_W-1:0]     free_bit;
  logic [CNT_W-1:0]     hint_base;
  logic [CNT_W-1:0]     lim;
  logic [WORD_BITS-1:0] rd_data, avail, set_mask, clr_mask, wr_data;
  logic                 found;
  logic [BIT_W-1:0]     fbit;
  logic [CNT_W-1:0]     found_idx;
  logic [NB_W-1:0]      next_base;
  logic                 free_ok;
  logic                 ram_we;
  logic [ROW_W-1:0]     ram_waddr;
  logic [SH_W-1:0]      shifted, diff;
  logic                 ge;
  logic [SIZE_W-1:0]    rem_nx;
  logic [CNT_W-1:0]     quo_nx;

  assign prod      = PROD_W'(plane_q) * PROD_W'(size_z_q);
  assign count_sat = (prod > PROD_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(prod);
  assign free_idx  = CNT_W'(req_q.free_id);
  assign free_row  = ROW_W'(free_idx / WORD_BITS);
  assign free_bit  = BIT_W'(free_idx % WORD_BITS);
  assign hint_base = CNT_W'(hint_q) * CNT_W'(WORD_BITS);
  assign free_ok   = CMP_W'(req_q.free_id) < CMP_W'(count_q);
  assign lim       = count_q - base_q;
  assign next_base = NB_W'(base_q) + NB_W'(WORD_BITS);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = ~rd_data[b] & (CNT_W'(b) < lim);
    end
  end

  always_comb begin
    found = 1'b0;
    fbit  = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found = 1'b1;
        fbit  = BIT_W'(b);
      end
    end
  end

  assign found_idx = base_q + CNT_W'(fbit);
  assign set_mask  = WORD_BITS'(1) << fbit;
  assign clr_mask  = WORD_BITS'(1) << free_bit;

  always_comb begin
    if (ctl_i.clr_wr) begin
      wr_data = '0;
    end else if (ctl_i.wr_alloc) begin
      wr_data = rd_data | set_mask;
    end else begin
      wr_data = rd_data & ~clr_mask;
    end
  end

  assign ram_we    = ctl_i.clr_wr | ctl_i.wr_alloc | ctl_i.wr_free;
  assign ram_waddr = ctl_i.clr_wr ? clr_row_q : row_q;

  ffba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_data),
    .re_i    (ctl_i.rd),
    .raddr_i (row_q),
    .rdata_o (rd_data)
  );

  assign shifted = {rem_q, quo_q[CNT_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign rem_nx  = ge ? SIZE_W'(diff) : SIZE_W'(shifted);
  assign quo_nx  = (quo_q << 1) | CNT_W'(ge);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q    <= SIZE_RESET;
      size_y_q    <= SIZE_RESET;
      size_z_q    <= SIZE_RESET;
      hint_q      <= '0;
      clr_row_q   <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIZE_X: size_x_q <= cfg_data_i;
          REG_SIZE_Y: size_y_q <= cfg_data_i;
          REG_SIZE_Z: size_z_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctl_i.clr_wr) begin
        clr_row_q <= clr_row_q + ROW_W'(1);
      end
      if (ctl_i.wr_alloc) begin
        hint_q <= row_q;
      end else if (ctl_i.wr_free && (free_row < hint_q)) begin
        hint_q <= free_row;
      end
      if (ctl_i.div_ld_x || ctl_i.div_ld_y) begin
        dcnt_q <= DCNT_W'(CNT_W);
      end else if (ctl_i.div_step) begin
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
      if (ctl_i.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      req_q <= in_data_i;
    end
    if (ctl_i.mul_plane) begin
      plane_q <= PLANE_W'(size_x_q) * PLANE_W'(size_y_q);
    end
    if (ctl_i.mul_count) begin
      count_q <= count_sat;
    end
    if (ctl_i.scan_init) begin
      if (req_q.cmd == CMD_FREE) begin
        row_q <= free_row;
      end else begin
        row_q  <= hint_q;
        base_q <= hint_base;
      end
    end else if (ctl_i.next_row) begin
      row_q  <= row_q + ROW_W'(1);
      base_q <= CNT_W'(next_base);
    end
    if (ctl_i.wr_alloc) begin
      idx_q <= found_idx;
    end
    if (ctl_i.div_ld_x) begin
      quo_q <= found_idx;
      rem_q <= '0;
      dvs_q <= size_x_q;
    end else if (ctl_i.div_ld_y) begin
      x_q   <= rem_q;
      rem_q <= '0;
      dvs_q <= size_y_q;
    end else if (ctl_i.div_step) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
    if (ctl_i.ld_out) begin
      out_q.status <= ctl_i.status;
      if (ctl_i.status == ST_ALLOC) begin
        out_q.brick_id <= BRICK_ID_W'(idx_q);
        out_q.coord_x  <= COORD_W'(x_q);
        out_q.coord_y  <= COORD_W'(rem_q);
        out_q.coord_z  <= COORD_W'(quo_q);
      end else begin
        out_q.brick_id <= '0;
        out_q.coord_x  <= '0;
        out_q.coord_y  <= '0;
        out_q.coord_z  <= '0;
      end
    end
  end

  assign sts_o.clr_last   = (clr_row_q == ROW_W'(ROWS - 1));
  assign sts_o.req_free   = (req_q.cmd == CMD_FREE);
  assign sts_o.free_ok    = free_ok;
  assign sts_o.alloc_none = (hint_base >= count_q);
  assign sts_o.found      = found;
  assign sts_o.more_rows  = (next_base < NB_W'(count_q));
  assign sts_o.div_last   = (dcnt_q == DCNT_W'(1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FFBA_ASSERT(a_out_no_overwrite, ctl_i.ld_out |-> (!out_valid_q || !out_stall_i), "result register overwritten while held")
  `FFBA_ASSERT(a_alloc_in_range, ctl_i.wr_alloc |-> (found && (found_idx < count_q)), "allocated slot outside slot count")
  `FFBA_ASSERT(a_rem_below_divisor, (dcnt_q != '0) |-> (rem_q < dvs_q), "divider remainder not below divisor")
  `FFBA_ASSERT_RST(a_reset_no_result, !rst_ni |=> !out_valid_q, "result valid during reset")

endmodule

`default_nettype wire

// ----- src/first_free_brick_allocator_unit.sv -----
// Allocate time is dominated by the restoring divider (one quotient bit a cycle, run twice),
// and grows with each extra bitmap row scanned (64 slots a row). A free out of range ends
// without a bitmap access; atlas full ends early when the search hint is past the slot count,
// else after the scan of the remaining rows. One transaction at a time: the next is taken once
// the previous result is in the output register. Reset: sizes return to 16; a clearing pass
// zeroes the bitmap with input stalled.
`timescale 1ns / 1ps
`default_nettype none

module first_free_brick_allocator_unit import ffba_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ffba_in_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ffba_out_t                 out_data_o
);

  ffba_ctl_t ctl;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ffba_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the first-free brick allocator: directed cases, then random
// bursts of allocate and free transactions over many atlas sizes, checked against a bitmap
// predictor in the bench. Depends on ffba_pkg and first_free_brick_allocator_unit.
`timescale 1ns / 1ps

module testbench;
  import ffba_pkg::*;

  localparam int unsigned SLOT_CAP     = 4096;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 200;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx = REG_SIZE_X;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  ffba_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ffba_out_t            out_data;

  // predictor state
  bit                   slot_used [SLOT_CAP];
  logic [SIZE_W-1:0]    atlas_x = SIZE_RESET;
  logic [SIZE_W-1:0]    atlas_y = SIZE_RESET;
  logic [SIZE_W-1:0]    atlas_z = SIZE_RESET;

  ffba_in_t             item_queue [$];
  ffba_out_t            pending_results [$];
  ffba_out_t            want;

  int unsigned items_issued = 0;
  int unsigned in_accepts = 0;
  int unsigned out_accepts = 0;
  int unsigned stuck_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 1;
  int unsigned n_alloc = 0;
  int unsigned n_full = 0;
  int unsigned n_freed = 0;
  int unsigned n_range = 0;
  int unsigned in_stalled_cycles = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 300;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;

  logic [SIZE_W-1:0] fixed_x [9] = '{7'd3, 7'd64, 7'd1, 7'd5, 7'd127, 7'd2, 7'd16, 7'd8, 7'd2};
  logic [SIZE_W-1:0] fixed_y [9] = '{7'd2, 7'd1, 7'd64, 7'd7, 7'd1, 7'd2, 7'd16, 7'd8, 7'd1};
  logic [SIZE_W-1:0] fixed_z [9] = '{7'd2, 7'd1, 7'd1, 7'd3, 7'd1, 7'd0, 7'd16, 7'd2, 7'd127};

  first_free_brick_allocator_unit #(
    .MAX_SLOTS(SLOT_CAP)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic int unsigned atlas_slots();
    int unsigned n;
    n = int'(atlas_x) * int'(atlas_y) * int'(atlas_z);
    if (n > SLOT_CAP) n = SLOT_CAP;
    return n;
  endfunction

  function automatic ffba_out_t brick_predict(ffba_in_t item);
    ffba_out_t   res;
    int unsigned count;
    int unsigned plane;
    bit          hit;
    res = '0;
    hit = 1'b0;
    count = atlas_slots();
    if (item.cmd == CMD_ALLOC) begin
      res.status = ST_FULL;
      for (int unsigned i = 0; i < count; i++) begin
        if (!hit && !slot_used[i]) begin
          hit = 1'b1;
          slot_used[i] = 1'b1;
          plane = int'(atlas_x) * int'(atlas_y);
          res.status   = ST_ALLOC;
          res.brick_id = 12'(i);
          res.coord_x  = 6'(i % atlas_x);
          res.coord_y  = 6'((i % plane) / atlas_x);
          res.coord_z  = 6'(i / plane);
        end
      end
    end else if (item.free_id < count) begin
      slot_used[item.free_id] = 1'b0;
      res.status = ST_FREED;
    end else begin
      res.status = ST_RANGE;
    end
    return res;
  endfunction

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst_n && !(in_valid && in_accepts != items_issued)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (item_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= item_queue.pop_front();
        items_issued++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: pattern of its own, plus long hold-offs to back the block up
  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (out_accepts >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      next_hold_at += 600;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 96);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= (rx_tick % 4 == 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      stuck_cycles++;
      if (cfg_we) stuck_cycles = 0;
      if (in_valid && in_stall) in_stalled_cycles++;
      if (out_valid && !out_stall) begin
        stuck_cycles = 0;
        out_accepts++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d: st=%0d id=%0d x=%0d y=%0d z=%0d", out_accepts,
                     out_data.status, out_data.brick_id, out_data.coord_x, out_data.coord_y,
                     out_data.coord_z);
        end else begin
          want = pending_results.pop_front();
          case (want.status)
            ST_ALLOC: n_alloc++;
            ST_FULL:  n_full++;
            ST_FREED: n_freed++;
            default:  n_range++;
          endcase
          if (out_data.status !== want.status || out_data.brick_id !== want.brick_id ||
              out_data.coord_x !== want.coord_x || out_data.coord_y !== want.coord_y ||
              out_data.coord_z !== want.coord_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: expected st=%0d id=%0d x=%0d y=%0d z=%0d, %s",
                       out_accepts, want.status, want.brick_id, want.coord_x, want.coord_y,
                       want.coord_z,
                       $sformatf("got st=%0d id=%0d x=%0d y=%0d z=%0d", out_data.status,
                                 out_data.brick_id, out_data.coord_x, out_data.coord_y,
                                 out_data.coord_z));
          end
        end
      end
      if (in_valid && !in_stall) begin
        stuck_cycles = 0;
        in_accepts++;
        pending_results.push_back(brick_predict(in_data));
      end
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("first_free_brick_allocator_unit verification failed");
    $finish;
  end

  task automatic push_item(input ffba_cmd_e cmd, input logic [ID_W-1:0] id);
    ffba_in_t item;
    item.cmd = cmd;
    item.free_id = id;
    item_queue.push_back(item);
  endtask

  task automatic write_size(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_SIZE_X: atlas_x = val;
      REG_SIZE_Y: atlas_y = val;
      default:    atlas_z = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_atlas(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                           input logic [SIZE_W-1:0] sz);
    write_size(REG_SIZE_X, sx);
    write_size(REG_SIZE_Y, sy);
    write_size(REG_SIZE_Z, sz);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (item_queue.size() != 0 || items_issued != in_accepts || pending_results.size() != 0)
      @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: return 7'd0;
        1: return 7'd1;
        2: return 7'd64;
        default: return 7'd127;
      endcase
    end
    return 7'($urandom_range(1, 8));
  endfunction

  task automatic queue_random_phase(input int unsigned n);
    ffba_in_t    item;
    int unsigned count;
    int unsigned alloc_pct;
    int unsigned roll;
    count = atlas_slots();
    alloc_pct = $urandom_range(35, 80);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        {item.cmd, item.free_id} = 17'($urandom);
      end else if ($urandom_range(0, 99) < alloc_pct) begin
        item.cmd = CMD_ALLOC;
        item.free_id = 16'($urandom);
      end else begin
        item.cmd = CMD_FREE;
        roll = $urandom_range(0, 99);
        if (count > 0 && roll < 75) item.free_id = 16'($urandom_range(0, count - 1));
        else if (roll < 88) item.free_id = 16'(count + $urandom_range(0, 3));
        else item.free_id = 16'($urandom);
      end
      item_queue.push_back(item);
    end
  endtask

  initial begin
    while (!rst_n) @(negedge clk);

    push_item(CMD_ALLOC, 16'h0000);
    push_item(CMD_ALLOC, 16'hFFFF);
    push_item(CMD_ALLOC, 16'h5A5A);
    push_item(CMD_FREE, 16'd1);
    push_item(CMD_ALLOC, 16'h0000);
    push_item(CMD_FREE, 16'hFFFF);
    push_item(CMD_FREE, 16'd4095);
    push_item(CMD_FREE, 16'd4096);
    push_item(CMD_FREE, 16'd0);
    push_item(CMD_ALLOC, 16'h0000);
    wait_idle();
    set_atlas(7'd1, 7'd1, 7'd1);
    push_item(CMD_FREE, 16'd0);
    push_item(CMD_ALLOC, 16'h0000);
    push_item(CMD_ALLOC, 16'h0000);
    push_item(CMD_FREE, 16'd1);
    wait_idle();
    set_atlas(7'd0, 7'd16, 7'd16);
    push_item(CMD_ALLOC, 16'h0000);
    push_item(CMD_FREE, 16'd0);
    wait_idle();
    set_atlas(7'd127, 7'd127, 7'd127);
    push_item(CMD_ALLOC, 16'h0000);
    push_item(CMD_FREE, 16'h8000);
    wait_idle();
    set_atlas(7'd64, 7'd64, 7'd64);
    push_item(CMD_ALLOC, 16'h0000);
    push_item(CMD_FREE, 16'd4095);
    push_item(CMD_FREE, 16'd4096);

    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p < 9) set_atlas(fixed_x[p], fixed_y[p], fixed_z[p]);
      else set_atlas(pick_size(), pick_size(), pick_size());
      queue_random_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("ran %0d transactions over %0d atlas settings, input stalled %0d cycles",
             in_accepts, settings_used, in_stalled_cycles);
    $display("results: %0d allocated, %0d full, %0d freed, %0d out of range",
             n_alloc, n_full, n_freed, n_range);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("first_free_brick_allocator_unit verification clean");
    end else begin
      $display("first_free_brick_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
